@@ rtl/sdta_pkg.sv @@
// ----------------------------------------------------------------------------
// sdta_pkg
// Shared types, sizes and codes of the scan result aggregator.
// ----------------------------------------------------------------------------
package sdta_pkg;

    localparam int SEEN_DEPTH = 96;
    localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
    localparam int SEEN_CW    = $clog2(SEEN_DEPTH + 1);
    localparam int LIST_DEPTH = 18;
    localparam int LIST_AW    = $clog2(LIST_DEPTH);
    localparam int LIST_CW    = $clog2(LIST_DEPTH + 1);
    localparam int HIST_CH    = 15;
    localparam int HIST_AW    = $clog2(HIST_CH);

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  PEAK_NONE = 8'sd0 - 8'sd127;
    localparam logic [7:0]  PPN_RESET = 8'd5;
    localparam logic [7:0]  SAVE_RESET = 8'd10;

    localparam int IN_W  = 72;
    localparam int OUT_W = 184;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_ENTRY = 2'd1,
        CMD_END   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [7:0] {
        REG_POINTS = 8'd0,
        REG_SAVE   = 8'd1
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_BEGIN, S_HASH, S_SEARCH, S_HIST_RD, S_HIST_WR,
        S_INS_CHK, S_INS_FULL, S_INS_STEP, S_INS_CMP,
        S_END_RD, S_END_CMP, S_END_FIN, S_END_MOD,
        S_LST_RD, S_LST_CAP, S_DONE
    } t_state;

    // one top list slot
    typedef struct packed {
        logic        open_net;
        logic [7:0]  channel;
        logic [7:0]  rssi;
        logic [31:0] hash;
    } t_slot;

endpackage

@@ rtl/sdta_hash.sv @@
// ----------------------------------------------------------------------------
// sdta_hash
// FNV-1a 32 over six address bytes, one byte and one multiply per cycle.
// ----------------------------------------------------------------------------
module sdta_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_addr,
    output logic        o_done,
    output logic [31:0] o_hash
);
    logic [31:0] r_h;
    logic [47:0] r_addr;
    logic [2:0]  r_k;
    logic        r_busy;
    logic        r_done;
    logic [7:0]  w_byte;

    assign w_byte = r_addr[{r_k, 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_h    <= sdta_pkg::FNV_BASIS;
                r_addr <= i_addr;
            end else if (r_busy) begin
                r_h <= (r_h ^ {24'd0, w_byte}) * sdta_pkg::FNV_PRIME;
                r_k <= r_k + 3'd1;
                if (r_k == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    // zero is reserved for an absent address
    assign o_hash = (r_h == 32'd0) ? 32'd1 : r_h;
endmodule

@@ rtl/sdta_mod.sv @@
// ----------------------------------------------------------------------------
// sdta_mod
// Bit-serial remainder of a 32 bit count by an 8 bit interval.
// ----------------------------------------------------------------------------
module sdta_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [7:0]  i_den,
    output logic        o_done,
    output logic [7:0]  o_rem
);
    logic [31:0] r_num;
    logic [7:0]  r_den;
    logic [7:0]  r_rem;
    logic [5:0]  r_k;
    logic        r_busy;
    logic        r_done;
    logic [8:0]  w_t;
    logic [8:0]  w_d;

    assign w_t = {r_rem, r_num[31]};
    assign w_d = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_k    <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                r_rem <= (w_t >= {1'b0, r_den}) ? w_d[7:0] : w_t[7:0];
                r_k   <= r_k + 6'd1;
                if (r_k == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

@@ rtl/scan_result_dedup_topk_aggregator.sv @@
// ----------------------------------------------------------------------------
// scan_result_dedup_topk_aggregator
// Radio scan aggregator: seen address set, channel histogram, top list.
// ----------------------------------------------------------------------------
// One request at a time. An end request reads the histogram bins in turn, then
// runs a bit-serial remainder. A network entry is hashed one byte per cycle
// through a single 32x32 multiply, then the seen-set search reads each stored
// hash in turn (up to 96, one memory read port), the histogram is updated and
// top list slots of weaker level are shifted down, the last one dropping off
// when the list is full. The seen set is a ring buffer, so the oldest hash is
// overwritten once it is full. s_axis_tready is high only while idle; the
// result sits in an output register until taken. Config writes are always
// taken.
module scan_result_dedup_topk_aggregator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // bssid[47:0] bssid_present[48] rssi[56:49] channel[64:57] open_net[65]
    // list_index[70:66], zero pad
    input  logic [sdta_pkg::IN_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // new_this_scan[15:0] near_count[20:16] strongest_rssi[28:21]
    // best_channel[32:29] total_seen[64:33] points[96:65] scan_count[128:97]
    // save_request[129] entry_hash[161:130] entry_rssi[169:162]
    // entry_channel[177:170] entry_open[178], zero pad
    output logic [sdta_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [7:0]                  i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);
    sdta_pkg::t_state r_state, n_state;

    // latched request
    logic              r_present;
    logic signed [7:0] r_rssi;
    logic [7:0]        r_chan;
    logic              r_open;
    logic [4:0]        r_idx;
    logic [31:0]       r_hash;
    logic              r_known;

    // config
    logic [7:0] r_ppn, r_save_int;

    // aggregate state
    logic [sdta_pkg::SEEN_CW-1:0] r_seen_cnt;
    logic [sdta_pkg::SEEN_AW-1:0] r_seen_head;
    logic [sdta_pkg::LIST_CW-1:0] r_list_cnt;
    logic [15:0]                  r_scan_new;
    logic signed [7:0]            r_peak;
    logic [3:0]                   r_busiest;
    logic [sdta_pkg::HIST_CH-1:0] r_hist_vld;
    logic [31:0]                  r_unique, r_points, r_scans;
    logic                         r_save;
    sdta_pkg::t_slot              r_entry;

    // sequencer working regs
    logic [sdta_pkg::SEEN_CW-1:0] r_si;
    logic                         r_pend;
    logic [sdta_pkg::LIST_AW-1:0] r_pos;
    logic [sdta_pkg::HIST_AW-1:0] r_c;
    logic [7:0]                   r_best;

    // memories
    logic [31:0]     r_seen_mem [sdta_pkg::SEEN_DEPTH];
    logic [31:0]     r_seen_rd;
    sdta_pkg::t_slot r_list_mem [sdta_pkg::LIST_DEPTH];
    sdta_pkg::t_slot r_list_rd;
    logic [7:0]      r_hist_mem [sdta_pkg::HIST_CH];
    logic [7:0]      r_hist_rd;

    logic                         list_re, list_we, hist_re, hist_we;
    logic [sdta_pkg::LIST_AW-1:0] list_raddr, list_waddr;
    sdta_pkg::t_slot              list_wdata, w_new;
    logic [sdta_pkg::HIST_AW-1:0] hist_raddr;
    logic                         mod_start;

    logic        s_acc, m_acc, w_chan_ok, w_search_go;
    logic [7:0]  w_hist_val;
    sdta_pkg::t_cmd w_cmd;

    logic        hash_done, mod_done;
    logic [31:0] hash_val;
    logic [7:0]  mod_rem;

    // output register
    logic                        r_out_valid;
    logic [sdta_pkg::OUT_W-1:0]  r_out;

    assign w_cmd         = sdta_pkg::t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_state == sdta_pkg::S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = r_out_valid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_chan_ok     = (r_chan < 8'(sdta_pkg::HIST_CH));
    assign w_search_go   = (r_si < r_seen_cnt);
    assign w_new         = '{open_net: r_open, channel: r_chan, rssi: r_rssi, hash: r_hash};
    assign w_hist_val    = r_hist_vld[r_c] ? r_hist_rd : 8'd0;

    sdta_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_acc && (w_cmd == sdta_pkg::CMD_ENTRY) && s_axis_tdata[48]),
        .i_addr  (s_axis_tdata[47:0]),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    sdta_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num   (r_scans + 32'd1),
        .i_den   (r_save_int),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdta_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory strobes
    always_comb begin
        n_state    = r_state;
        list_re    = 1'b0;
        list_we    = 1'b0;
        list_raddr = r_pos - sdta_pkg::LIST_AW'(1);
        list_waddr = r_pos;
        list_wdata = w_new;
        hist_re    = 1'b0;
        hist_we    = 1'b0;
        hist_raddr = r_chan[sdta_pkg::HIST_AW-1:0];
        mod_start  = 1'b0;
        case (r_state)
            sdta_pkg::S_IDLE: begin
                if (s_acc) begin
                    case (w_cmd)
                        sdta_pkg::CMD_BEGIN: n_state = sdta_pkg::S_BEGIN;
                        sdta_pkg::CMD_ENTRY: n_state = sdta_pkg::S_HASH;
                        sdta_pkg::CMD_END:   n_state = sdta_pkg::S_END_RD;
                        default:             n_state = sdta_pkg::S_LST_RD;
                    endcase
                end
            end
            sdta_pkg::S_BEGIN: n_state = sdta_pkg::S_DONE;
            sdta_pkg::S_HASH: begin
                if (!r_present) begin
                    n_state = sdta_pkg::S_HIST_RD;
                end else if (hash_done) begin
                    n_state = sdta_pkg::S_SEARCH;
                end
            end
            sdta_pkg::S_SEARCH: begin
                if (!w_search_go && !r_pend) begin
                    n_state = sdta_pkg::S_HIST_RD;
                end
            end
            sdta_pkg::S_HIST_RD: begin
                hist_re = w_chan_ok;
                n_state = sdta_pkg::S_HIST_WR;
            end
            sdta_pkg::S_HIST_WR: begin
                hist_we = w_chan_ok;
                n_state = sdta_pkg::S_INS_CHK;
            end
            sdta_pkg::S_INS_CHK: begin
                if (r_list_cnt >= sdta_pkg::LIST_CW'(sdta_pkg::LIST_DEPTH)) begin
                    list_re    = 1'b1;
                    list_raddr = sdta_pkg::LIST_AW'(sdta_pkg::LIST_DEPTH - 1);
                    n_state    = sdta_pkg::S_INS_FULL;
                end else begin
                    n_state = sdta_pkg::S_INS_STEP;
                end
            end
            sdta_pkg::S_INS_FULL: begin
                if ($signed(r_list_rd.rssi) >= r_rssi) begin
                    n_state = sdta_pkg::S_DONE;
                end else begin
                    n_state = sdta_pkg::S_INS_STEP;
                end
            end
            sdta_pkg::S_INS_STEP: begin
                if (r_pos == '0) begin
                    list_we = 1'b1;
                    n_state = sdta_pkg::S_DONE;
                end else begin
                    list_re = 1'b1;
                    n_state = sdta_pkg::S_INS_CMP;
                end
            end
            sdta_pkg::S_INS_CMP: begin
                list_we = 1'b1;
                if ($signed(r_list_rd.rssi) < r_rssi) begin
                    list_wdata = r_list_rd;
                    n_state    = sdta_pkg::S_INS_STEP;
                end else begin
                    n_state = sdta_pkg::S_DONE;
                end
            end
            sdta_pkg::S_END_RD: begin
                hist_re    = 1'b1;
                hist_raddr = r_c;
                n_state    = sdta_pkg::S_END_CMP;
            end
            sdta_pkg::S_END_CMP: begin
                if (r_c == sdta_pkg::HIST_AW'(sdta_pkg::HIST_CH - 1)) begin
                    n_state = sdta_pkg::S_END_FIN;
                end else begin
                    n_state = sdta_pkg::S_END_RD;
                end
            end
            sdta_pkg::S_END_FIN: begin
                mod_start = 1'b1;
                n_state   = sdta_pkg::S_END_MOD;
            end
            sdta_pkg::S_END_MOD: begin
                if (mod_done) begin
                    n_state = sdta_pkg::S_DONE;
                end
            end
            sdta_pkg::S_LST_RD: begin
                list_re    = 1'b1;
                list_raddr = r_idx[sdta_pkg::LIST_AW-1:0];
                n_state    = sdta_pkg::S_LST_CAP;
            end
            sdta_pkg::S_LST_CAP: n_state = sdta_pkg::S_DONE;
            sdta_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = sdta_pkg::S_IDLE;
                end
            end
            default: n_state = sdta_pkg::S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_seen_rd <= r_seen_mem[r_si[sdta_pkg::SEEN_AW-1:0]];
        if (r_state == sdta_pkg::S_HIST_RD && !r_known) begin
            if (r_seen_cnt < sdta_pkg::SEEN_CW'(sdta_pkg::SEEN_DEPTH)) begin
                r_seen_mem[r_seen_cnt[sdta_pkg::SEEN_AW-1:0]] <= r_hash;
            end else begin
                r_seen_mem[r_seen_head] <= r_hash;
            end
        end
        if (list_re) begin
            r_list_rd <= r_list_mem[list_raddr];
        end
        if (list_we) begin
            r_list_mem[list_waddr] <= list_wdata;
        end
        if (hist_re) begin
            r_hist_rd <= r_hist_mem[hist_raddr];
        end
        if (hist_we) begin
            r_hist_mem[hist_raddr] <= (r_hist_vld[hist_raddr] ? r_hist_rd : 8'd0) + 8'd1;
        end
    end

    // datapath and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppn       <= sdta_pkg::PPN_RESET;
            r_save_int  <= sdta_pkg::SAVE_RESET;
            r_seen_cnt  <= '0;
            r_seen_head <= '0;
            r_list_cnt  <= '0;
            r_scan_new  <= '0;
            r_peak      <= sdta_pkg::PEAK_NONE;
            r_busiest   <= '0;
            r_hist_vld  <= '0;
            r_unique    <= '0;
            r_points    <= '0;
            r_scans     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (sdta_pkg::t_reg'(i_cfg_index))
                    sdta_pkg::REG_POINTS: r_ppn      <= i_cfg_data;
                    sdta_pkg::REG_SAVE:   r_save_int <= i_cfg_data;
                    default: ;
                endcase
            end
            // in the done state the output register is reloaded below instead
            if (m_acc && r_state != sdta_pkg::S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                sdta_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_present <= s_axis_tdata[48];
                        r_rssi    <= $signed(s_axis_tdata[56:49]);
                        r_chan    <= s_axis_tdata[64:57];
                        r_open    <= s_axis_tdata[65];
                        r_idx     <= s_axis_tdata[70:66];
                        r_hash    <= '0;
                        r_known   <= 1'b1;
                        r_save    <= 1'b0;
                        r_entry   <= '0;
                        r_si      <= '0;
                        r_pend    <= 1'b0;
                        r_c       <= sdta_pkg::HIST_AW'(1);
                        r_best    <= '0;
                    end
                end
                sdta_pkg::S_BEGIN: begin
                    r_list_cnt <= '0;
                    r_scan_new <= '0;
                    r_peak     <= sdta_pkg::PEAK_NONE;
                    r_busiest  <= '0;
                    r_hist_vld <= '0;
                end
                sdta_pkg::S_HASH: begin
                    if (hash_done) begin
                        r_hash  <= hash_val;
                        r_known <= 1'b0;
                    end
                end
                sdta_pkg::S_SEARCH: begin
                    r_pend <= w_search_go;
                    if (w_search_go) begin
                        r_si <= r_si + sdta_pkg::SEEN_CW'(1);
                    end
                    if (r_pend && r_seen_rd == r_hash) begin
                        r_known <= 1'b1;
                    end
                end
                sdta_pkg::S_HIST_RD: begin
                    if (r_rssi > r_peak) begin
                        r_peak <= r_rssi;
                    end
                    if (!r_known) begin
                        r_unique   <= r_unique + 32'd1;
                        r_scan_new <= r_scan_new + 16'd1;
                        r_points   <= r_points + {24'd0, r_ppn};
                        if (r_seen_cnt < sdta_pkg::SEEN_CW'(sdta_pkg::SEEN_DEPTH)) begin
                            r_seen_cnt <= r_seen_cnt + sdta_pkg::SEEN_CW'(1);
                        end else if (r_seen_head ==
                                     sdta_pkg::SEEN_AW'(sdta_pkg::SEEN_DEPTH - 1)) begin
                            r_seen_head <= '0;
                        end else begin
                            r_seen_head <= r_seen_head + sdta_pkg::SEEN_AW'(1);
                        end
                    end
                end
                sdta_pkg::S_HIST_WR: begin
                    if (w_chan_ok) begin
                        r_hist_vld[hist_raddr] <= 1'b1;
                    end
                end
                sdta_pkg::S_INS_CHK: begin
                    if (r_list_cnt >= sdta_pkg::LIST_CW'(sdta_pkg::LIST_DEPTH)) begin
                        r_pos <= sdta_pkg::LIST_AW'(sdta_pkg::LIST_DEPTH - 1);
                    end else begin
                        r_pos      <= r_list_cnt[sdta_pkg::LIST_AW-1:0];
                        r_list_cnt <= r_list_cnt + sdta_pkg::LIST_CW'(1);
                    end
                end
                sdta_pkg::S_INS_CMP: begin
                    r_pos <= r_pos - sdta_pkg::LIST_AW'(1);
                end
                sdta_pkg::S_END_CMP: begin
                    // strict compare keeps the lowest channel on a tie
                    if (w_hist_val > r_best) begin
                        r_best    <= w_hist_val;
                        r_busiest <= 4'(r_c);
                    end
                    r_c <= r_c + sdta_pkg::HIST_AW'(1);
                end
                sdta_pkg::S_END_FIN: begin
                    r_scans <= r_scans + 32'd1;
                end
                sdta_pkg::S_END_MOD: begin
                    if (mod_done) begin
                        r_save <= (r_scan_new != 16'd0) ||
                                  (r_save_int != 8'd0 && mod_rem == 8'd0);
                    end
                end
                sdta_pkg::S_LST_CAP: begin
                    if ({1'b0, r_idx} < 6'(r_list_cnt)) begin
                        r_entry <= r_list_rd;
                    end
                end
                sdta_pkg::S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out <= {5'd0, r_entry.open_net, r_entry.channel, r_entry.rssi,
                                  r_entry.hash, r_save, r_scans, r_points, r_unique,
                                  r_busiest, r_peak, 5'(r_list_cnt), r_scan_new};
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // checks
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_cnt <= sdta_pkg::SEEN_CW'(sdta_pkg::SEEN_DEPTH))
        else $error("seen count past depth");
    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_list_cnt <= sdta_pkg::LIST_CW'(sdta_pkg::LIST_DEPTH))
        else $error("list count past depth");
    a_hash_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> r_state == sdta_pkg::S_HASH)
        else $error("hash done outside hash phase");
    a_mod_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == sdta_pkg::S_END_MOD)
        else $error("remainder done outside end phase");
    a_ring_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_head != '0 |-> r_seen_cnt == sdta_pkg::SEEN_CW'(sdta_pkg::SEEN_DEPTH))
        else $error("ring head moved before set filled");
endmodule

@@ tb/sv/scan_result_dedup_topk_aggregator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_result_dedup_topk_aggregator_test
// Streams scan requests (begin, entries, end, list reads) through the
// aggregator under several idling phases and register settings, and checks
// every result against an in-bench model of the seen set and the top list.
// ----------------------------------------------------------------------------
module scan_result_dedup_topk_aggregator_test;

    // one input request as the bench sees it
    typedef struct {
        sdta_pkg::t_cmd cmd;
        logic [47:0]    bssid;
        logic           present;
        logic [7:0]     rssi;
        logic [7:0]     chan;
        logic           open_net;
        logic [4:0]     idx;
    } t_req;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [sdta_pkg::IN_W-1:0]     s_axis_tdata;
    logic [1:0]                    s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [sdta_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [7:0]                    i_cfg_index;
    logic [7:0]                    i_cfg_data;

    scan_result_dedup_topk_aggregator dut (.*);

    // --- model state ---
    logic [7:0]      mdl_ppn;
    logic [7:0]      mdl_save_int;
    logic [31:0]     seen_set[$];
    sdta_pkg::t_slot top_slots[$];
    logic [15:0]     scan_new;
    logic [7:0]      peak;
    logic [3:0]      busiest;
    logic [7:0]      hist[sdta_pkg::HIST_CH];
    logic [31:0]     uniq_total;
    logic [31:0]     point_total;
    logic [31:0]     scans_done;

    t_req                        pending_reqs[$];
    logic [sdta_pkg::OUT_W-1:0]  expected_results[$];
    int                          errors;
    int                          results_seen;
    int                          send_idle_pct;
    int                          recv_stall_pct;
    int                          hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("scan_result_dedup_topk_aggregator test failed");
        $finish;
    end

    function automatic logic [31:0] fnv_hash(input logic [47:0] addr);
        logic [31:0] h;
        h = sdta_pkg::FNV_BASIS;
        for (int i = 0; i < 6; i++) begin
            h = h ^ {24'd0, addr[8*i +: 8]};
            h = h * sdta_pkg::FNV_PRIME;
        end
        return (h == 32'd0) ? 32'd1 : h;
    endfunction

    // Apply one request to the model and return the result word it should give
    function automatic logic [sdta_pkg::OUT_W-1:0] aggregate_request(input t_req r);
        logic [sdta_pkg::OUT_W-1:0] o;
        logic            save;
        sdta_pkg::t_slot e;
        sdta_pkg::t_slot rd;
        logic [31:0]     h;
        logic            known;
        int              pos;
        logic [7:0]      best;
        save = 1'b0;
        rd = '0;
        case (r.cmd)
            sdta_pkg::CMD_BEGIN: begin
                top_slots.delete();
                scan_new = '0;
                peak = sdta_pkg::PEAK_NONE;
                busiest = '0;
                foreach (hist[c]) hist[c] = '0;
            end
            sdta_pkg::CMD_ENTRY: begin
                h = r.present ? fnv_hash(r.bssid) : 32'd0;
                if ($signed(r.rssi) > $signed(peak)) peak = r.rssi;
                if (r.chan < sdta_pkg::HIST_CH) hist[r.chan] = hist[r.chan] + 8'd1;
                known = (h == 32'd0);
                foreach (seen_set[i]) if (seen_set[i] == h) known = 1'b1;
                if (!known) begin
                    if (seen_set.size() == sdta_pkg::SEEN_DEPTH) void'(seen_set.pop_front());
                    seen_set.push_back(h);
                    uniq_total++;
                    scan_new++;
                    point_total += {24'd0, mdl_ppn};
                end
                e.hash = h;
                e.rssi = r.rssi;
                e.channel = r.chan;
                e.open_net = r.open_net;
                // stable insertion: goes after every entry of equal or higher level
                if (top_slots.size() < sdta_pkg::LIST_DEPTH ||
                    $signed(r.rssi) >
                    $signed(top_slots[sdta_pkg::LIST_DEPTH-1].rssi)) begin
                    if (top_slots.size() == sdta_pkg::LIST_DEPTH)
                        void'(top_slots.pop_back());
                    pos = top_slots.size();
                    while (pos > 0 && $signed(top_slots[pos-1].rssi) < $signed(r.rssi))
                        pos--;
                    top_slots.insert(pos, e);
                end
            end
            sdta_pkg::CMD_END: begin
                best = '0;
                for (int c = 1; c < sdta_pkg::HIST_CH; c++) begin
                    if (hist[c] > best) begin
                        best = hist[c];
                        busiest = c[3:0];
                    end
                end
                scans_done++;
                save = (scan_new != 0) ||
                       (mdl_save_int != 0 && (scans_done % mdl_save_int) == 0);
            end
            default: begin
                if (r.idx < top_slots.size()) rd = top_slots[r.idx];
            end
        endcase
        o = '0;
        o[15:0]    = scan_new;
        o[20:16]   = 5'(top_slots.size());
        o[28:21]   = peak;
        o[32:29]   = busiest;
        o[64:33]   = uniq_total;
        o[96:65]   = point_total;
        o[128:97]  = scans_done;
        o[129]     = save;
        o[161:130] = rd.hash;
        o[169:162] = rd.rssi;
        o[177:170] = rd.channel;
        o[178]     = rd.open_net;
        return o;
    endfunction

    // --- driver: takes requests from the pending queue ---
    // the request on the bus stays at the head of the queue until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                expected_results.push_back(aggregate_request(pending_reqs.pop_front()));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req n;
                n = pending_reqs[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= n.cmd;
                s_axis_tdata  <= {1'b0, n.idx, n.open_net, n.chan, n.rssi, n.present, n.bssid};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // --- receiver stall and monitor ---
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                end else begin
                    logic [sdta_pkg::OUT_W-1:0] x;
                    x = expected_results.pop_front();
                    if (x !== m_axis_tdata) begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, x, m_axis_tdata);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic add_req(input sdta_pkg::t_cmd c, input logic [47:0] a, input logic p,
                           input logic [7:0] lv, input logic [7:0] ch,
                           input logic op, input logic [4:0] ix);
        t_req r;
        r.cmd = c; r.bssid = a; r.present = p; r.rssi = lv;
        r.chan = ch; r.open_net = op; r.idx = ix;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input sdta_pkg::t_reg idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == sdta_pkg::REG_POINTS) mdl_ppn = val; else mdl_save_int = val;
    endtask

    // A scan: mostly reused addresses from a small pool so the seen set hits
    task automatic random_scan(input int n_entries, input int pool);
        add_req(sdta_pkg::CMD_BEGIN, {16'($urandom()), 32'($urandom())}, 1'($urandom()),
                8'($urandom()), 8'($urandom()), 1'($urandom()), 5'($urandom()));
        for (int i = 0; i < n_entries; i++) begin
            logic [47:0] a;
            int k;
            k = $urandom_range(9);
            if (k < 6) a = 48'($urandom_range(pool)) * 48'h0000_1357_9BDF;
            else a = {16'($urandom()), 32'($urandom())};
            add_req(($urandom_range(19) == 0) ? sdta_pkg::t_cmd'($urandom_range(3))
                                              : sdta_pkg::CMD_ENTRY,
                    a, ($urandom_range(9) != 0), 8'($urandom()),
                    ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(15)),
                    1'($urandom()), 5'($urandom_range(19)));
        end
        add_req(sdta_pkg::CMD_END, '1, 1'b1, 8'h80, 8'hFF, 1'b1, 5'h1F);
        for (int i = 0; i < 4; i++)
            add_req(sdta_pkg::CMD_READ, 48'($urandom()), 1'($urandom()), 8'($urandom()),
                    8'($urandom()), 1'($urandom()), 5'($urandom_range(31)));
    endtask

    initial begin
        logic [7:0] ppn_vals[4];
        logic [7:0] save_vals[4];
        ppn_vals  = '{8'd0, 8'd255, 8'd1, 8'd5};
        save_vals = '{8'd255, 8'd1, 8'd0, 8'd3};
        errors = 0; results_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = sdta_pkg::CMD_BEGIN;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = sdta_pkg::REG_POINTS; i_cfg_data = '0;
        mdl_ppn = sdta_pkg::PPN_RESET; mdl_save_int = sdta_pkg::SAVE_RESET;
        scan_new = '0; peak = sdta_pkg::PEAK_NONE; busiest = '0;
        foreach (hist[c]) hist[c] = '0;
        uniq_total = '0; point_total = '0; scans_done = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reads on empty list, extremes, absent address, ties, out-of-range channel and index
        add_req(sdta_pkg::CMD_READ, '0, 1'b0, 8'h00, 8'h00, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_END, '0, 1'b0, 8'h00, 8'h00, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_BEGIN, '0, 1'b0, 8'h00, 8'h00, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, '0, 1'b0, 8'h80, 8'd0, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, '1, 1'b1, 8'h7F, 8'd14, 1'b1, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, '1, 1'b1, 8'h7F, 8'd15, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, 48'h0, 1'b1, 8'h81, 8'd255, 1'b1, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, 48'hA5A5_5A5A_0F0F, 1'b1, 8'h81, 8'd3, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, 48'h5A5A_A5A5_F0F0, 1'b1, 8'h00, 8'd3, 1'b1, 5'd0);
        add_req(sdta_pkg::CMD_ENTRY, 48'h1234_5678_9ABC, 1'b1, 8'h00, 8'd14, 1'b0, 5'd0);
        add_req(sdta_pkg::CMD_END, '0, 1'b0, 8'h00, 8'h00, 1'b0, 5'd0);
        for (int i = 0; i < 7; i++)
            add_req(sdta_pkg::CMD_READ, '0, 1'b0, 8'h00, 8'h00, 1'b0, 5'(i * 3));
        add_req(sdta_pkg::CMD_READ, '0, 1'b0, 8'h00, 8'h00, 1'b0, 5'd31);
        drain();
        write_reg(sdta_pkg::REG_POINTS, 8'd255);
        write_reg(sdta_pkg::REG_SAVE, 8'd1);

        // list overflow and seen set wrap: many fresh entries in one scan
        random_scan(120, 1 << 30);
        drain();

        // phases of idling with different register settings
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 66) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 66) : 0;
            write_reg(sdta_pkg::REG_POINTS, ppn_vals[ph]);
            write_reg(sdta_pkg::REG_SAVE, save_vals[ph]);
            for (int s = 0; s < 15; s++) random_scan($urandom_range(25), 60);
            if (ph == 0) begin
                // long receiver hold-off while the sender keeps offering
                hold_off_cycles <= 3000;
                @(posedge i_clk);
            end
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;

        $display("covered %0d results over begin/entry/end/read requests,", results_seen);
        $display("seen set wrap, top list overflow and four register settings");
        if (errors == 0) begin
            $display("scan_result_dedup_topk_aggregator test passed");
        end else begin
            $display("scan_result_dedup_topk_aggregator test failed");
        end
        $finish;
    end
endmodule
